FILE: rtl/mic_pkg.sv
package mic_pkg;

   // Averaging window in samples, range 1 to 16
   localparam int WINDOW   = 5;
   localparam bit HAS_HIST = (WINDOW > 1);
   localparam int HIST_N   = (WINDOW > 1) ? WINDOW - 1 : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int AXES     = 3;
   localparam int DATA_W   = 16;

   // Reciprocal table: floor(2^16 / d) for d = 1..16, entry 0 unused
   localparam int RECIP_W   = 17;
   localparam int TBL_IDX_W = 5;
   localparam logic [RECIP_W-1:0] RECIP_TBL [17] = '{
      17'd0,
      17'(65536 / 1),  17'(65536 / 2),  17'(65536 / 3),  17'(65536 / 4),
      17'(65536 / 5),  17'(65536 / 6),  17'(65536 / 7),  17'(65536 / 8),
      17'(65536 / 9),  17'(65536 / 10), 17'(65536 / 11), 17'(65536 / 12),
      17'(65536 / 13), 17'(65536 / 14), 17'(65536 / 15), 17'(65536 / 16)
   };

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Event codes
   localparam logic [1:0] EV_NONE      = 2'd0;
   localparam logic [1:0] EV_PULL_OVER = 2'd1;
   localparam logic [1:0] EV_SIDE      = 2'd2;
   localparam logic [1:0] EV_FRONT     = 2'd3;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_THR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPACT_THR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_THR = 3'd5;

   typedef struct packed {
      logic [AXES-1:0][DATA_W-1:0] start;
      logic [DATA_W-1:0]           lift_thr;
      logic [DATA_W-1:0]           impact_thr;
      logic [DATA_W-1:0]           height_thr;
   } mic_cfg_type;

   localparam mic_cfg_type CFG_RESET = '{
      start:      {16'd960, 16'd10, 16'hFFF6},
      lift_thr:   16'd50,
      impact_thr: 16'd1000,
      height_thr: 16'd80
   };

   // One summed sample on its way to the back end
   typedef struct packed {
      logic [AXES-1:0][DATA_W-1:0] sum;
      logic [CNT_W-1:0]            div;
      logic                        first;
      logic                        last;
      logic [DATA_W-1:0]           height;
   } mic_work_type;

endpackage

FILE: rtl/motion_impact_classifier.sv
// Motion impact classifier.
// Input channel (req_): one three-axis acceleration sample per item, with the
// current height and a mark on the final sample of a frame. The item is taken
// at a rising edge with req_valid high and req_stall low.
// Each sample is averaged with up to four earlier samples of its frame; the
// per-axis high and low peaks start each frame from the start registers.
// Result channel (rsp_): one item per frame, after its last sample, carrying
// the event code and the x, y and z swings. Taken when rsp_valid is high and
// rsp_stall is low; a stalled result holds steady.
// The back end takes a new sample only once its two-stage divide and peak
// unit is through with the last one. A two-entry queue decouples the front
// end, so samples are accepted back to back until the queue fills.
// The last sample passes the queue and both back-end stages before rsp_valid rises.
// A stalled result holds the back end only when the next last sample is due;
// mid-frame samples keep flowing meanwhile.
// Register writes (csr_) are always ready; write them while idle.
// Reset: synchronous, clears the queue, window sums, counters, busy and result
// flags and restores the register defaults. No clearing pass is needed.
module motion_impact_classifier import mic_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_acc_x,
   input  logic signed [15:0] req_acc_y,
   input  logic signed [15:0] req_acc_z,
   input  logic signed [15:0] req_height_cm,
   input  logic               req_last_in_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_code,
   output logic [15:0]        rsp_swing_x,
   output logic [15:0]        rsp_swing_y,
   output logic [15:0]        rsp_swing_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   mic_cfg_type  cfg_ff, cfg_in;
   mic_work_type push_data;
   mic_work_type pop_data;
   logic         push;
   logic         pop;
   logic         fifo_full;
   logic         fifo_not_empty;

   // Register file: always ready; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_X:    cfg_in.start[0]   = csr_wdata;
            CSR_START_Y:    cfg_in.start[1]   = csr_wdata;
            CSR_START_Z:    cfg_in.start[2]   = csr_wdata;
            CSR_LIFT_THR:   cfg_in.lift_thr   = csr_wdata;
            CSR_IMPACT_THR: cfg_in.impact_thr = csr_wdata;
            CSR_HEIGHT_THR: cfg_in.height_thr = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: window sums and frame tracking
   mic_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_acc_x         (req_acc_x),
      .req_acc_y         (req_acc_y),
      .req_acc_z         (req_acc_z),
      .req_height_cm     (req_height_cm),
      .req_last_in_frame (req_last_in_frame),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_data         (push_data)
   );

   // Hold up to two summed samples between the halves
   mic_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (fifo_not_empty)
   );

   // Back end: divide, peak tracking, event decision and result register
   mic_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .not_empty      (fifo_not_empty),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .rsp_swing_x    (rsp_swing_x),
      .rsp_swing_y    (rsp_swing_y),
      .rsp_swing_z    (rsp_swing_z)
   );

endmodule

FILE: rtl/mic_front.sv
module mic_front import mic_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_acc_x,
   input  logic signed [15:0] req_acc_y,
   input  logic signed [15:0] req_acc_z,
   input  logic signed [15:0] req_height_cm,
   input  logic               req_last_in_frame,
   input  logic               fifo_full,
   output logic               push,
   output mic_work_type       push_data
);

   logic [AXES-1:0][DATA_W-1:0] tap_ff [HIST_N];
   logic [AXES-1:0][DATA_W-1:0] tap_in [HIST_N];
   logic [DATA_W-1:0]           hsum_ff [AXES];
   logic [DATA_W-1:0]           hsum_in [AXES];
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        first_ff, first_in;
   logic [AXES-1:0][DATA_W-1:0] raw;
   logic                        accept;
   logic                        full;

   assign req_stall = fifo_full;
   assign accept    = req_valid & ~fifo_full;
   assign push      = accept;
   assign raw       = {req_acc_z, req_acc_y, req_acc_x};
   assign full      = HAS_HIST && (count_ff == CNT_W'(WINDOW - 1));

   always_comb begin
      tap_in   = tap_ff;
      hsum_in  = hsum_ff;
      count_in = count_ff;
      first_in = first_ff;
      for (int a = 0; a < AXES; a++) begin
         push_data.sum[a] = DATA_W'(hsum_ff[a] + raw[a]);
      end
      push_data.div    = CNT_W'(count_ff + 1'b1);
      push_data.first  = first_ff;
      push_data.last   = req_last_in_frame;
      push_data.height = req_height_cm;
      if (accept) begin
         first_in = req_last_in_frame;
         // shift in the newest sample; the oldest drops off tap 0
         for (int i = 0; i < HIST_N - 1; i++) begin
            tap_in[i] = tap_ff[i + 1];
         end
         tap_in[HIST_N - 1] = raw;
         for (int a = 0; a < AXES; a++) begin
            if (req_last_in_frame || !HAS_HIST) begin
               hsum_in[a] = '0;
            end else if (full) begin
               hsum_in[a] = DATA_W'(hsum_ff[a] - tap_ff[0][a] + raw[a]);
            end else begin
               hsum_in[a] = DATA_W'(hsum_ff[a] + raw[a]);
            end
         end
         if (req_last_in_frame) begin
            count_in = '0;
         end else if (HAS_HIST && !full) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
      if (reset) begin
         hsum_ff  <= '{default: '0};
         count_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         hsum_ff  <= hsum_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: rtl/mic_fifo.sv
module mic_fifo import mic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  mic_work_type push_data,
   output logic         full,
   input  logic         pop,
   output mic_work_type pop_data,
   output logic         not_empty
);

   mic_work_type          mem_ff [FIFO_DEPTH];
   mic_work_type          mem_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      mem_in = mem_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         mem_in[wr_ff] = push_data;
         wr_in = (wr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : FIFO_PTR_W'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : FIFO_PTR_W'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = FIFO_CNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = FIFO_CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from empty queue");

endmodule

FILE: rtl/mic_back.sv
module mic_back import mic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mic_cfg_type  cfg,
   input  logic         not_empty,
   input  mic_work_type pop_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_event_code,
   output logic [15:0]  rsp_swing_x,
   output logic [15:0]  rsp_swing_y,
   output logic [15:0]  rsp_swing_z
);

   localparam int PROD_W = DATA_W + RECIP_W;
   localparam int QD_W   = DATA_W + CNT_W;

   logic                     busy_ff, busy_in;
   logic                     neg_ff [AXES];
   logic                     neg_in [AXES];
   logic [DATA_W-1:0]        mag_ff [AXES];
   logic [DATA_W-1:0]        mag_in [AXES];
   logic [PROD_W-1:0]        prod_ff [AXES];
   logic [PROD_W-1:0]        prod_in [AXES];
   logic [CNT_W-1:0]         div_ff, div_in;
   logic                     first_ff, first_in;
   logic                     last_ff, last_in;
   logic [DATA_W-1:0]        height_ff, height_in;
   logic signed [DATA_W-1:0] hi_ff [AXES];
   logic signed [DATA_W-1:0] hi_in [AXES];
   logic signed [DATA_W-1:0] lo_ff [AXES];
   logic signed [DATA_W-1:0] lo_in [AXES];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               event_ff, event_in;
   logic [DATA_W-1:0]        swing_ff [AXES];
   logic [DATA_W-1:0]        swing_in [AXES];

   logic                     hold;
   logic                     done;
   logic [RECIP_W-1:0]       recip;
   logic [DATA_W-1:0]        sum_s;
   logic [DATA_W-1:0]        q0;
   logic [DATA_W-1:0]        q;
   logic [QD_W-1:0]          qd;
   logic [DATA_W:0]          rem;
   logic signed [DATA_W-1:0] avg;
   logic signed [DATA_W-1:0] new_hi [AXES];
   logic signed [DATA_W-1:0] new_lo [AXES];
   logic [DATA_W-1:0]        sw [AXES];
   logic [1:0]               ev;

   assign pop   = not_empty & ~busy_ff;
   // a last item waits while the previous result is still unread
   assign hold  = busy_ff & last_ff & rsp_valid_ff & rsp_stall;
   assign done  = busy_ff & ~hold;
   assign recip = RECIP_TBL[TBL_IDX_W'(pop_data.div)];

   // Stage one: magnitude times reciprocal
   always_comb begin
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      height_in = height_ff;
      sum_s     = '0;
      if (pop) begin
         for (int a = 0; a < AXES; a++) begin
            sum_s      = pop_data.sum[a];
            neg_in[a]  = sum_s[DATA_W-1];
            mag_in[a]  = sum_s[DATA_W-1] ? DATA_W'(~sum_s + 1'b1) : sum_s;
            prod_in[a] = PROD_W'(mag_in[a]) * PROD_W'(recip);
         end
         div_in    = pop_data.div;
         first_in  = pop_data.first;
         last_in   = pop_data.last;
         height_in = pop_data.height;
      end
   end

   // Stage two: correct quotient, update peaks, form result
   always_comb begin
      q0  = '0;
      qd  = '0;
      rem = '0;
      q   = '0;
      avg = '0;
      for (int a = 0; a < AXES; a++) begin
         q0  = prod_ff[a][DATA_W + 15:16];
         qd  = QD_W'(q0) * QD_W'(div_ff);
         rem = (DATA_W + 1)'({1'b0, mag_ff[a]} - qd[DATA_W:0]);
         q   = (rem >= (DATA_W + 1)'(div_ff)) ? DATA_W'(q0 + 1'b1) : q0;
         avg = neg_ff[a] ? $signed(DATA_W'(~q + 1'b1)) : $signed(q);
         new_hi[a] = first_ff ? $signed(cfg.start[a]) : hi_ff[a];
         new_lo[a] = first_ff ? $signed(cfg.start[a]) : lo_ff[a];
         if (avg < new_lo[a]) begin
            new_lo[a] = avg;
         end else if (avg > new_hi[a]) begin
            new_hi[a] = avg;
         end
         sw[a] = DATA_W'(new_hi[a] - new_lo[a]);
      end
      if (sw[2] > cfg.lift_thr && $signed(height_ff) > $signed(cfg.height_thr)) begin
         ev = EV_PULL_OVER;
      end else if (sw[0] > cfg.impact_thr && sw[0] > sw[1]) begin
         ev = EV_SIDE;
      end else if (sw[1] > cfg.impact_thr && sw[1] > sw[0]) begin
         ev = EV_FRONT;
      end else begin
         ev = EV_NONE;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      event_in     = event_ff;
      swing_in     = swing_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      if (done) begin
         hi_in = new_hi;
         lo_in = new_lo;
         if (last_ff) begin
            event_in     = ev;
            swing_in     = sw;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      height_ff <= height_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      event_ff  <= event_in;
      swing_ff  <= swing_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = event_ff;
   assign rsp_swing_x    = swing_ff[0];
   assign rsp_swing_y    = swing_ff[1];
   assign rsp_swing_z    = swing_ff[2];

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> busy_ff) else $error("popped item not loaded");

   a_mid_frame_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !last_ff) |=> !busy_ff) else $error("mid-frame item stuck");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (done && last_ff) |=> rsp_valid_ff) else $error("last item gave no result");

endmodule

FILE: tb/motion_impact_classifier_test.sv
module motion_impact_classifier_test import mic_pkg::*;;

   // Run bounds. Each item can meet a long sender gap and a long receiver
   // stall, so the cycle budget is taken well over the slowest honest run.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 165;

   // Register indexes beyond the last register: the block must drop these
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Flavours of random frame content
   localparam int MODE_RAW    = 0;
   localparam int MODE_NEAR   = 1;
   localparam int MODE_SWING  = 2;
   localparam int MODE_CORNER = 3;

   localparam logic [15:0] CORNER_VALUES [5] = '{
      16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001
   };

   typedef struct packed {
      logic [15:0] acc_x;
      logic [15:0] acc_y;
      logic [15:0] acc_z;
      logic [15:0] height_cm;
      logic        last;
   } accel_item_type;

   typedef struct packed {
      logic [1:0]  event_code;
      logic [15:0] swing_x;
      logic [15:0] swing_y;
      logic [15:0] swing_z;
   } frame_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_acc_x = '0;
   logic [15:0] req_acc_y = '0;
   logic [15:0] req_acc_z = '0;
   logic [15:0] req_height_cm = '0;
   logic        req_last_in_frame = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_code;
   logic [15:0] rsp_swing_x;
   logic [15:0] rsp_swing_y;
   logic [15:0] rsp_swing_z;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   motion_impact_classifier DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_acc_x         (req_acc_x),
      .req_acc_y         (req_acc_y),
      .req_acc_z         (req_acc_z),
      .req_height_cm     (req_height_cm),
      .req_last_in_frame (req_last_in_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_swing_x       (rsp_swing_x),
      .rsp_swing_y       (rsp_swing_y),
      .rsp_swing_z       (rsp_swing_z),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Classifier mirror: register copy plus frame state, reset values first
   // ---------------------------------------------------------------------
   logic signed [15:0] start_level [3] = '{-16'sd10, 16'sd10, 16'sd960};
   logic [15:0]        lift_limit   = 16'd50;
   logic [15:0]        impact_limit = 16'd1000;
   logic signed [15:0] height_limit = 16'sd80;

   logic [15:0] window_hist [HIST_N][3];
   int          hist_fill  = 0;
   int          peak_hi [3];
   int          peak_lo [3];
   bit          frame_live = 1'b0;

   // Traffic between the stimulus, the driver and the result checker
   accel_item_type    samples_to_send [$];
   frame_outcome_type outcomes_due [$];
   accel_item_type    bus_item;
   frame_outcome_type fresh_outcome;
   frame_outcome_type due;
   bit                item_on_bus = 1'b0;
   bit                calm = 1'b0;
   int                send_gap = 0;
   int                stall_left = 0;

   int mismatches = 0;
   int samples_taken = 0;
   int frames_closed = 0;
   int settings_written = 0;
   int event_tally [4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   // Apply a register write to the mirror; indexes past the last are dropped
   function automatic void apply_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
         CSR_START_X:    start_level[0] = data;
         CSR_START_Y:    start_level[1] = data;
         CSR_START_Z:    start_level[2] = data;
         CSR_LIFT_THR:   lift_limit     = data;
         CSR_IMPACT_THR: impact_limit   = data;
         CSR_HEIGHT_THR: height_limit   = data;
         default: ;
      endcase
   endfunction

   // Advance the mirror by one accepted item; return 1 when it closes a frame
   function automatic bit classify_sample(input accel_item_type it,
                                          output frame_outcome_type o);
      logic [15:0] raw [3];
      logic [15:0] sum;
      logic [15:0] swing [3];
      int          avg;
      raw[0] = it.acc_x;
      raw[1] = it.acc_y;
      raw[2] = it.acc_z;
      o = '0;
      // Open a frame: peaks restart from the start registers
      if (!frame_live) begin
         for (int a = 0; a < 3; a++) begin
            peak_hi[a] = int'(start_level[a]);
            peak_lo[a] = int'(start_level[a]);
         end
         hist_fill  = 0;
         frame_live = 1'b1;
      end
      // Truncating average over the window; the sum wraps at 16 bits
      for (int a = 0; a < 3; a++) begin
         sum = raw[a];
         for (int k = 0; k < hist_fill; k++)
            sum = sum + window_hist[k][a];
         avg = int'($signed(sum)) / (hist_fill + 1);
         if (avg < peak_lo[a])
            peak_lo[a] = avg;
         else if (avg > peak_hi[a])
            peak_hi[a] = avg;
      end
      // Keep the newest raw samples, dropping the oldest once full
      if (WINDOW > 1) begin
         if (hist_fill >= HIST_N) begin
            for (int k = 0; k < HIST_N - 1; k++)
               window_hist[k] = window_hist[k + 1];
            hist_fill = HIST_N - 1;
         end
         window_hist[hist_fill] = raw;
         hist_fill++;
      end
      if (!it.last)
         return 1'b0;
      for (int a = 0; a < 3; a++)
         swing[a] = 16'(peak_hi[a] - peak_lo[a]);
      if (swing[2] > lift_limit && $signed(it.height_cm) > height_limit)
         o.event_code = EV_PULL_OVER;
      else if (swing[0] > impact_limit && swing[0] > swing[1])
         o.event_code = EV_SIDE;
      else if (swing[1] > impact_limit && swing[1] > swing[0])
         o.event_code = EV_FRONT;
      else
         o.event_code = EV_NONE;
      o.swing_x = swing[0];
      o.swing_y = swing[1];
      o.swing_z = swing[2];
      // Close the frame and clear the history
      frame_live = 1'b0;
      hist_fill  = 0;
      for (int k = 0; k < HIST_N; k++)
         window_hist[k] = '{3{16'h0000}};
      return 1'b1;
   endfunction

   // Mostly short gaps, now and then a long one; none at all when calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(40, 13);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offer the next pending item, hold it while stalled, predict
   // the outcome on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         item_on_bus  = 1'b0;
         send_gap     = 0;
      end else begin
         if (item_on_bus && !req_stall) begin
            item_on_bus = 1'b0;
            samples_taken++;
            if (classify_sample(bus_item, fresh_outcome))
               outcomes_due.push_back(fresh_outcome);
         end
         if (!item_on_bus) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               bus_item    = samples_to_send.pop_front();
               item_on_bus = 1'b1;
               send_gap    = pick_gap();
               req_valid         <= 1'b1;
               req_acc_x         <= bus_item.acc_x;
               req_acc_y         <= bus_item.acc_y;
               req_acc_z         <= bus_item.acc_z;
               req_height_cm     <= bus_item.height_cm;
               req_last_in_frame <= bus_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest outcome
   // still due, and stall the result channel at random
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $error("unexpected result: event_code %0d swings %0d %0d %0d",
                      rsp_event_code, rsp_swing_x, rsp_swing_y, rsp_swing_z);
               mismatches++;
            end else begin
               due = outcomes_due.pop_front();
               check_field("event_code", 16'(due.event_code), 16'(rsp_event_code));
               check_field("swing_x", due.swing_x, rsp_swing_x);
               check_field("swing_y", due.swing_y, rsp_swing_y);
               check_field("swing_z", due.swing_z, rsp_swing_z);
               frames_closed++;
               event_tally[due.event_code]++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, outcomes_due.size());
         $display("motion_impact_classifier_test: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void queue_item(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                      logic [15:0] h, bit last);
      accel_item_type it;
      it = '{acc_x: x, acc_y: y, acc_z: z, height_cm: h, last: last};
      samples_to_send.push_back(it);
   endfunction

   function automatic accel_item_type make_item(int mode, bit last);
      accel_item_type it;
      logic [15:0] ax [3];
      for (int a = 0; a < 3; a++) begin
         case (mode)
            MODE_RAW:   ax[a] = 16'($urandom);
            MODE_NEAR:  ax[a] = 16'(int'(start_level[a]) + int'($urandom_range(1200)) - 600);
            MODE_SWING: ax[a] = 16'(int'(start_level[a]) + int'($urandom_range(24000)) - 12000);
            default:    ax[a] = CORNER_VALUES[$urandom_range(4)];
         endcase
      end
      it.acc_x = ax[0];
      it.acc_y = ax[1];
      it.acc_z = ax[2];
      // Height either anywhere or hugging the threshold
      if ($urandom_range(1))
         it.height_cm = 16'($urandom);
      else
         it.height_cm = 16'(int'(height_limit) + int'($urandom_range(400)) - 200);
      it.last = last;
      return it;
   endfunction

   // Wait until nothing is queued, on the bus or due, then let the back end
   // finish any sample that produces no result
   task automatic settle();
      while (samples_to_send.size() != 0 || item_on_bus || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(idx, data);
      settings_written++;
   endtask

   task automatic program_all(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                              logic [15:0] lift, logic [15:0] impact, logic [15:0] height);
      write_register(CSR_START_X, sx);
      write_register(CSR_START_Y, sy);
      write_register(CSR_START_Z, sz);
      write_register(CSR_LIFT_THR, lift);
      write_register(CSR_IMPACT_THR, impact);
      write_register(CSR_HEIGHT_THR, height);
      // Out-of-range index: must leave every register alone
      write_register($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
   endtask

   // Whole frames of random length and flavour, then drain
   task automatic run_random_phase(int target);
      int sent, len, mode, r;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(99);
         len = (r < 15) ? 1 : (r < 85) ? $urandom_range(8, 2) : $urandom_range(16, 9);
         r = $urandom_range(99);
         mode = (r < 20) ? MODE_RAW : (r < 70) ? MODE_NEAR : (r < 90) ? MODE_SWING
                                                                       : MODE_CORNER;
         for (int k = 0; k < len; k++)
            samples_to_send.push_back(make_item(mode, k == len - 1));
         sent += len;
      end
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values.
      // One-sample frames at both extremes: taken unaveraged.
      queue_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      queue_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
      // Longer than the window, with sums that wrap
      queue_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
      queue_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
      queue_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0);
      queue_item(16'h8000, 16'h8000, 16'h0001, 16'h0000, 1'b0);
      queue_item(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000, 1'b0);
      queue_item(16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b1);
      // Pull-over: z lifts well past the threshold with height above its limit
      queue_item(16'd0, 16'd10, 16'd960, 16'd100, 1'b0);
      queue_item(16'd0, 16'd10, 16'd2000, 16'd100, 1'b1);
      // Same lift, height exactly at its limit: no pull-over
      queue_item(16'd0, 16'd10, 16'd960, 16'd80, 1'b0);
      queue_item(16'd0, 16'd10, 16'd2000, 16'd80, 1'b1);
      // Side impact, then front impact
      queue_item(16'd3000, 16'd10, 16'd960, 16'd0, 1'b0);
      queue_item(-16'sd3000, 16'd10, 16'd960, 16'd0, 1'b1);
      queue_item(-16'sd10, 16'd3000, 16'd960, 16'd0, 1'b0);
      queue_item(-16'sd10, -16'sd3000, 16'd960, 16'd0, 1'b1);
      // Equal x and y swings above the impact threshold: no event
      queue_item(16'd1990, 16'd2010, 16'd960, 16'd0, 1'b1);
      settle();

      // Register write in the middle of a frame: the new start waits for
      // the next frame, the threshold counts at once
      queue_item(16'd100, 16'd100, 16'd100, 16'd0, 1'b0);
      settle();
      write_register(CSR_START_X, 16'd500);
      write_register(CSR_IMPACT_THR, 16'd0);
      queue_item(-16'sd100, 16'd100, 16'd100, 16'd0, 1'b1);
      settle();

      // Register extremes, low then high
      program_all(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
      run_random_phase(PHASE_ITEMS);
      program_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
      run_random_phase(PHASE_ITEMS);

      // Random settings, mostly sensible, sometimes anything; one phase
      // runs without gaps or stalls
      for (int p = 0; p < 6; p++) begin
         calm = (p == 2);
         if ($urandom_range(3) == 0)
            program_all(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
         else
            program_all(16'(int'($urandom_range(200)) - 100),
                        16'(int'($urandom_range(200)) - 100),
                        16'(900 + $urandom_range(200)),
                        16'($urandom_range(3000)),
                        16'($urandom_range(8000)),
                        16'(int'($urandom_range(400)) - 200));
         run_random_phase(PHASE_ITEMS);
      end
      calm = 1'b0;

      $display("run covered %0d samples in %0d frames over %0d register writes",
               samples_taken, frames_closed, settings_written);
      $display("events seen: none %0d, pull-over %0d, side %0d, front %0d; %0d mismatches",
               event_tally[EV_NONE], event_tally[EV_PULL_OVER], event_tally[EV_SIDE],
               event_tally[EV_FRONT], mismatches);
      if (mismatches == 0 && outcomes_due.size() == 0)
         $display("motion_impact_classifier_test: PASS");
      else
         $display("motion_impact_classifier_test: FAIL");
      $finish;
   end

endmodule

FILE: files.f
rtl/mic_pkg.sv
rtl/mic_front.sv
rtl/mic_fifo.sv
rtl/mic_back.sv
rtl/motion_impact_classifier.sv
tb/motion_impact_classifier_test.sv
